FILE: rtl/core/swsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsm_pkg
// Shared widths, register map, cell operations and control types of the
// sliding window spread tracker.
// ----------------------------------------------------------------------------
package swsm_pkg;

  localparam int SWSM_WINDOW_MAX  = 64;
  localparam int SWSM_SAMPLE_BITS = 32;

  localparam int DATA_W     = 32;  // sample and spread fields on the ports
  localparam int LEN_W      = 7;   // window_len register
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_WINDOW_LEN = 1'b0;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,   // take the left neighbour (new sample enters at cell 0)
    CELL_ROT      // take the right neighbour, last cell takes cell 0
  } cell_op_t;

  typedef struct packed {
    logic init;    // first element of the scan
    logic upd;     // element inside the window
    logic commit;  // fold spread into best
    logic clear;   // end of sequence, drop best
  } track_ctrl_t;

endpackage

FILE: rtl/core/swsm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsm_if
// Valid/ready channels for the sample stream and the result stream.
// ----------------------------------------------------------------------------
interface swsm_in_if import swsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sample;
  logic              is_last;

  modport source (output valid, sample, is_last, input ready);
  modport sink   (input valid, sample, is_last, output ready);
endinterface

interface swsm_out_if import swsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] window_spread;
  logic              window_full;
  logic [DATA_W-1:0] best_spread;
  logic              best_valid;
  logic              seq_end;

  modport source (output valid, window_spread, window_full, best_spread,
                  best_valid, seq_end, input ready);
  modport sink   (input valid, window_spread, window_full, best_spread,
                  best_valid, seq_end, output ready);
endinterface

FILE: rtl/core/swsm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsm_cell
// One window slot: shifts forward on a new sample, rotates back during scan.
// ----------------------------------------------------------------------------
module swsm_cell import swsm_pkg::*; #(
  parameter int W = SWSM_SAMPLE_BITS
) (
  input  logic         clk,
  input  cell_op_t     op,
  input  logic [W-1:0] prev_d,
  input  logic [W-1:0] next_d,
  output logic [W-1:0] q
);

  logic [W-1:0] data_r;
  logic [W-1:0] data_nxt;

  always_comb begin
    unique case (op)
      CELL_SHIFT: data_nxt = prev_d;
      CELL_ROT:   data_nxt = next_d;
      default:    data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

FILE: rtl/core/swsm_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsm_track
// Min/max accumulator fed from the head of the chain, plus best spread.
// ----------------------------------------------------------------------------
module swsm_track import swsm_pkg::*; #(
  parameter int W = SWSM_SAMPLE_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  track_ctrl_t  ctrl,
  input  logic [W-1:0] head,
  input  logic         full,
  output logic [W-1:0] spread,
  output logic [W-1:0] best,
  output logic         seen
);

  logic [W-1:0] lo_r, lo_nxt;
  logic [W-1:0] hi_r, hi_nxt;
  logic [W-1:0] best_r, best_nxt;
  logic         seen_r, seen_nxt;
  logic [W-1:0] diff;

  assign diff = hi_r - lo_r;

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (ctrl.init) begin
      lo_nxt = head;
      hi_nxt = head;
    end else if (ctrl.upd) begin
      if (head < lo_r) lo_nxt = head;
      if (head > hi_r) hi_nxt = head;
    end
  end

  always_comb begin
    best_nxt = best_r;
    if (full && (!seen_r || diff > best_r)) best_nxt = diff;
    seen_nxt = seen_r | full;
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (!rst_n) begin
      best_r <= '0;
      seen_r <= 1'b0;
    end else if (ctrl.commit) begin
      best_r <= ctrl.clear ? '0 : best_nxt;
      seen_r <= ctrl.clear ? 1'b0 : seen_nxt;
    end
  end

  assign spread = full ? diff : '0;
  assign best   = best_nxt;
  assign seen   = seen_nxt;

endmodule

FILE: rtl/core/sliding_window_spread_max.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_spread_max
// Window of the latest samples held in a chain of cells; the chain is rotated
// once round per sample to gather min/max, and the best spread is kept.
// ----------------------------------------------------------------------------
//  port      | dir | kind
//  in_chan   | in  | sample, is_last (valid/ready)
//  out_chan  | out | window_spread, window_full, best_spread, best_valid,
//            |     | seq_end (valid/ready)
//  psel..    | in  | APB register port, window_len at address 0
//
//  Each sample is handled in order: the accept cycle shifts it in, then a
//  full turn of the cell chain feeds the min/max unit, then a commit step.
//  The scan turns the whole chain because its single read point is cell 0.
//  Reset needs no clearing pass: the fill count keeps stale cells out of
//  every window. A sample is taken while the previous result still waits;
//  only the commit waits for the output register to free up.
// ----------------------------------------------------------------------------
module sliding_window_spread_max import swsm_pkg::*; #(
  parameter int WINDOW_MAX  = SWSM_WINDOW_MAX,
  parameter int SAMPLE_BITS = SWSM_SAMPLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  swsm_in_if.sink               in_chan,
  swsm_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SW    = (SAMPLE_BITS > DATA_W) ? DATA_W : SAMPLE_BITS;
  localparam int IDX_W = $clog2(WINDOW_MAX);
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t           state_r;
  logic [LEN_W-1:0] window_len_r;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] len_r;
  logic [IDX_W-1:0] idx_r;
  logic             full_r;
  logic             last_r;

  logic             out_valid_r;
  logic [DATA_W-1:0] out_spread_r;
  logic             out_full_r;
  logic [DATA_W-1:0] out_best_r;
  logic             out_bvalid_r;
  logic             out_end_r;

  logic [CNT_W-1:0] len_eff;
  logic [CNT_W-1:0] fill_inc;
  logic             in_xfer;
  logic             commit;
  logic             cfg_wr;
  cell_op_t         op;
  track_ctrl_t      tctrl;
  logic [SW-1:0]    new_sample;
  logic [SW-1:0]    q [WINDOW_MAX];
  logic [SW-1:0]    t_spread;
  logic [SW-1:0]    t_best;
  logic             t_seen;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_WINDOW_LEN);
  assign prdata = (paddr[2] == REG_WINDOW_LEN) ? APB_DATA_W'(window_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) window_len_r <= LEN_W'(1);
    else if (cfg_wr) window_len_r <= pwdata[LEN_W-1:0];
  end

  // zero acts as one, oversize clips to the chain length
  always_comb begin
    if (window_len_r == '0) len_eff = CNT_W'(1);
    else if (32'(window_len_r) > 32'(WINDOW_MAX)) len_eff = CNT_W'(WINDOW_MAX);
    else len_eff = CNT_W'(window_len_r);
  end

  assign fill_inc = (32'(fill_r) < 32'(WINDOW_MAX)) ? fill_r + CNT_W'(1) : fill_r;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid & in_chan.ready;
  assign commit        = (state_r == ST_DONE) & (!out_valid_r | out_chan.ready);
  assign new_sample    = in_chan.sample[SW-1:0];

  always_comb begin
    op = CELL_HOLD;
    if (in_xfer) op = CELL_SHIFT;
    else if (state_r == ST_SCAN) op = CELL_ROT;
  end

  always_comb begin
    tctrl.init   = (state_r == ST_SCAN) && (idx_r == '0);
    tctrl.upd    = (state_r == ST_SCAN) && (CNT_W'(idx_r) < len_r);
    tctrl.commit = commit;
    tctrl.clear  = last_r;
  end

  // cell chain
  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    logic [SW-1:0] prev_d;
    logic [SW-1:0] next_d;
    if (k == 0) begin : g_head
      assign prev_d = new_sample;
    end else begin : g_body
      assign prev_d = q[k-1];
    end
    if (k == WINDOW_MAX - 1) begin : g_tail
      assign next_d = q[0];
    end else begin : g_mid
      assign next_d = q[k+1];
    end
    swsm_cell #(.W(SW)) u_cell (
      .clk    (clk),
      .op     (op),
      .prev_d (prev_d),
      .next_d (next_d),
      .q      (q[k])
    );
  end

  swsm_track #(.W(SW)) u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (tctrl),
    .head   (q[0]),
    .full   (full_r),
    .spread (t_spread),
    .best   (t_best),
    .seen   (t_seen)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            fill_r  <= fill_inc;
            len_r   <= len_eff;
            full_r  <= fill_inc >= len_eff;
            last_r  <= in_chan.is_last;
            idx_r   <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          idx_r <= idx_r + IDX_W'(1);
          if (idx_r == IDX_W'(WINDOW_MAX - 1)) state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (commit) begin
            out_spread_r <= DATA_W'(t_spread);
            out_full_r   <= full_r;
            out_best_r   <= DATA_W'(t_best);
            out_bvalid_r <= t_seen;
            out_end_r    <= last_r;
            if (last_r) fill_r <= '0;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.window_spread = out_spread_r;
  assign out_chan.window_full   = out_full_r;
  assign out_chan.best_spread   = out_best_r;
  assign out_chan.best_valid    = out_bvalid_r;
  assign out_chan.seq_end       = out_end_r;

endmodule
